### sv/ccpe_pkg.sv
// ---------------------------------------------------------------------------
// ccpe_pkg: shared types and codes for the center crop / palette expand block
// Holds the input and result word layouts, register indexes, format and
// action codes, and the per-axis mapping result passed between modules.
// ---------------------------------------------------------------------------
package ccpe_pkg;

    // Width of each size register and of the configuration data bus.
    localparam int CFG_W = 13;
    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;
    // Width of an emitted coordinate.
    localparam int COORD_W = 12;
    // Width of one color channel and of a palette index.
    localparam int CHAN_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ENABLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FORMAT = 3'd6;

    // Image encodings.
    localparam logic FMT_INDEXED = 1'b0;
    localparam logic FMT_DIRECT  = 1'b1;

    // Input word actions.
    localparam logic ACT_PALETTE_WRITE = 1'b0;
    localparam logic ACT_PIXEL         = 1'b1;

    typedef struct packed {
        logic              action;
        logic [CHAN_W-1:0] palette_slot;
        logic [CHAN_W-1:0] pixel_index;
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
    } in_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [CHAN_W-1:0]  out_index;
        logic [CHAN_W-1:0]  out_red;
        logic [CHAN_W-1:0]  out_green;
        logic [CHAN_W-1:0]  out_blue;
        logic               frame_last;
        logic               format_error;
    } out_word_t;

    // What one axis mapper reports for the current source position.
    typedef struct packed {
        logic               hit;    // position lies inside the kept window
        logic               last;   // position is the last kept one
        logic               wrap;   // counter wraps after this position
        logic [COORD_W-1:0] coord;  // destination coordinate
    } axis_map_t;

endpackage

### sv/center_crop_palette_expand_top.sv
// ---------------------------------------------------------------------------
// center_crop_palette_expand_top: streaming center crop with palette lookup
// Maps a raster-order source image onto a destination frame of another size
// and re-encodes each kept pixel, expanding indexes through a palette.
// ---------------------------------------------------------------------------
// Usage:
// The source channel (src_valid, src_ready, src_word) carries one word per
// handshake: either a palette entry write or the next source pixel in raster
// order. The destination channel (dst_valid, dst_ready, dst_word) carries one
// word for every pixel that lands in the destination frame, with its
// destination coordinates; pixels outside the kept window produce nothing.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register
// per cycle; the user must only write it while the block is idle, as the
// block itself does not enforce this. Throughput is one source word per
// clock while the receiver keeps taking words. A kept pixel is loaded into
// the mapping stage at the edge that accepts it, then into the output register,
// from which it is offered. The mapping stage does the window mapping and
// the palette read; the output register fills in the palette color.
// When the receiver stalls, the output register holds its word and the
// mapping stage still takes one more word, so the source side backs up only
// once both stages are full.
// Reset clears the pixel counters, the pipeline valid flags and the
// configuration registers (sizes to one, centering on, both formats indexed).
// The palette is not cleared; an entry must be written before it is used.
// ---------------------------------------------------------------------------
module center_crop_palette_expand_top #(
    parameter int MAX_DIM       = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ccpe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ccpe_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                src_valid,
    output logic                                src_ready,
    input  ccpe_pkg::in_word_t                  src_word,
    output logic                                dst_valid,
    input  logic                                dst_ready,
    output ccpe_pkg::out_word_t                 dst_word
);

    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int PAL_AW = $clog2(PALETTE_DEPTH);
    localparam int RGB_W  = 3 * ccpe_pkg::CHAN_W;

    // Configuration registers.
    logic [ccpe_pkg::CFG_W-1:0] src_w_reg;
    logic [ccpe_pkg::CFG_W-1:0] src_h_reg;
    logic [ccpe_pkg::CFG_W-1:0] dst_w_reg;
    logic [ccpe_pkg::CFG_W-1:0] dst_h_reg;
    logic                       center_reg;
    logic                       src_fmt_reg;
    logic                       dst_fmt_reg;

    // Source position of the next pixel.
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] row_next;

    // Palette storage and its registered read port.
    logic [RGB_W-1:0] palette_mem [PALETTE_DEPTH];
    logic [RGB_W-1:0] pal_rd_reg;

    // Mapping stage.
    logic                s1_valid_reg;
    logic                s1_valid_next;
    ccpe_pkg::out_word_t s1_word_reg;
    ccpe_pkg::out_word_t s1_word_next;
    logic                s1_use_pal_reg;
    logic                s1_use_pal_next;
    logic                s1_pal_hit_reg;
    logic                s1_pal_hit_next;

    // Output register.
    logic                out_valid_reg;
    logic                out_valid_next;
    ccpe_pkg::out_word_t out_word_reg;
    ccpe_pkg::out_word_t out_word_next;

    ccpe_pkg::axis_map_t map_x;
    ccpe_pkg::axis_map_t map_y;

    logic accept;
    logic pixel_in;
    logic pal_write;
    logic out_en;
    logic s1_en;
    logic err_mode;
    logic emit;
    logic slot_ok;
    logic index_ok;

    ccpe_axis_map #(
        .MAX_DIM (MAX_DIM)
    ) u_map_x (
        .src_size (src_w_reg),
        .dst_size (dst_w_reg),
        .center   (center_reg),
        .count    (col_reg),
        .map      (map_x)
    );

    ccpe_axis_map #(
        .MAX_DIM (MAX_DIM)
    ) u_map_y (
        .src_size (src_h_reg),
        .dst_size (dst_h_reg),
        .center   (center_reg),
        .count    (row_reg),
        .map      (map_y)
    );

    // Each stage advances when it is empty or its word moves on downstream.
    assign out_en    = !out_valid_reg || dst_ready;
    assign s1_en     = !s1_valid_reg || out_en;
    assign src_ready = s1_en;
    assign accept    = src_valid && s1_en;
    assign pixel_in  = accept && (src_word.action == ccpe_pkg::ACT_PIXEL);
    assign pal_write = accept && (src_word.action == ccpe_pkg::ACT_PALETTE_WRITE);

    // Slots and indexes beyond the palette are ignored on write and read as zero.
    assign slot_ok  = {1'b0, src_word.palette_slot} < 9'(PALETTE_DEPTH);
    assign index_ok = {1'b0, src_word.pixel_index} < 9'(PALETTE_DEPTH);

    // A direct source cannot feed an indexed destination; the frame then
    // reports a single error word at its first source pixel.
    assign err_mode = (src_fmt_reg == ccpe_pkg::FMT_DIRECT) &&
                      (dst_fmt_reg == ccpe_pkg::FMT_INDEXED);
    assign emit     = err_mode ? ((col_reg == '0) && (row_reg == '0))
                               : (map_x.hit && map_y.hit);

    always_comb
    begin
        s1_word_next = '0;
        if (err_mode)
        begin
            s1_word_next.frame_last   = 1'b1;
            s1_word_next.format_error = 1'b1;
        end
        else
        begin
            s1_word_next.out_x      = map_x.coord;
            s1_word_next.out_y      = map_y.coord;
            s1_word_next.frame_last = map_x.last && map_y.last;
            if (src_fmt_reg == ccpe_pkg::FMT_INDEXED && dst_fmt_reg == ccpe_pkg::FMT_INDEXED)
                s1_word_next.out_index = src_word.pixel_index;
            if (src_fmt_reg == ccpe_pkg::FMT_DIRECT)
            begin
                s1_word_next.out_red   = src_word.in_red;
                s1_word_next.out_green = src_word.in_green;
                s1_word_next.out_blue  = src_word.in_blue;
            end
        end
        s1_use_pal_next = !err_mode && (src_fmt_reg == ccpe_pkg::FMT_INDEXED) &&
                          (dst_fmt_reg == ccpe_pkg::FMT_DIRECT);
        s1_pal_hit_next = index_ok;
        s1_valid_next   = s1_en ? (pixel_in && emit) : s1_valid_reg;
    end

    // Raster counters: the column wraps at the source width (or at once when
    // it already lies beyond it), and the row steps on that wrap.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pixel_in)
        begin
            if (map_x.wrap)
            begin
                col_next = '0;
                row_next = map_y.wrap ? '0 : CNT_W'(row_reg + 1'b1);
            end
            else
            begin
                col_next = CNT_W'(col_reg + 1'b1);
            end
        end
    end

    // The output stage fills in the palette color for indexed-to-direct words.
    always_comb
    begin
        out_word_next  = s1_word_reg;
        if (s1_use_pal_reg)
        begin
            {out_word_next.out_red, out_word_next.out_green, out_word_next.out_blue} =
                s1_pal_hit_reg ? pal_rd_reg : '0;
        end
        out_valid_next = out_en ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg   <= ccpe_pkg::CFG_W'(1);
            src_h_reg   <= ccpe_pkg::CFG_W'(1);
            dst_w_reg   <= ccpe_pkg::CFG_W'(1);
            dst_h_reg   <= ccpe_pkg::CFG_W'(1);
            center_reg  <= 1'b1;
            src_fmt_reg <= ccpe_pkg::FMT_INDEXED;
            dst_fmt_reg <= ccpe_pkg::FMT_INDEXED;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ccpe_pkg::CFG_SOURCE_WIDTH:  src_w_reg   <= cfg_data;
                ccpe_pkg::CFG_SOURCE_HEIGHT: src_h_reg   <= cfg_data;
                ccpe_pkg::CFG_TARGET_WIDTH:  dst_w_reg   <= cfg_data;
                ccpe_pkg::CFG_TARGET_HEIGHT: dst_h_reg   <= cfg_data;
                ccpe_pkg::CFG_CENTER_ENABLE: center_reg  <= cfg_data[0];
                ccpe_pkg::CFG_SOURCE_FORMAT: src_fmt_reg <= cfg_data[0];
                ccpe_pkg::CFG_TARGET_FORMAT: dst_fmt_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_word_reg    <= s1_word_next;
            s1_use_pal_reg <= s1_use_pal_next;
            s1_pal_hit_reg <= s1_pal_hit_next;
        end
        if (out_en)
            out_word_reg <= out_word_next;
    end

    // Palette: written when a palette word is accepted, read at the pixel's
    // index at the same edge that captures the pixel into the mapping stage.
    always_ff @(posedge clk)
    begin
        if (pal_write && slot_ok)
            palette_mem[src_word.palette_slot[PAL_AW-1:0]] <=
                {src_word.in_red, src_word.in_green, src_word.in_blue};
        if (s1_en)
            pal_rd_reg <= palette_mem[src_word.pixel_index[PAL_AW-1:0]];
    end

    assign dst_valid = out_valid_reg;
    assign dst_word  = out_word_reg;

endmodule

### sv/ccpe_axis_map.sv
// ---------------------------------------------------------------------------
// ccpe_axis_map: crop / placement mapping for one image axis
// Clamps the source and destination sizes, derives the kept window and its
// destination offset, and classifies the current source position.
// ---------------------------------------------------------------------------
module ccpe_axis_map #(
    parameter int MAX_DIM = 4096
) (
    input  logic [ccpe_pkg::CFG_W-1:0]        src_size,
    input  logic [ccpe_pkg::CFG_W-1:0]        dst_size,
    input  logic                              center,
    input  logic [$clog2(MAX_DIM)-1:0]        count,
    output ccpe_pkg::axis_map_t               map
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int CMP_W = ((CNT_W > ccpe_pkg::CFG_W) ? CNT_W : ccpe_pkg::CFG_W) + 1;

    // A size of zero acts as one, a size above the maximum acts as the maximum.
    function automatic logic [CMP_W-1:0] clamp_dim(input logic [ccpe_pkg::CFG_W-1:0] v);
        logic [CMP_W-1:0] ext;
        begin
            ext = CMP_W'(v);
            if (ext == '0)
                return CMP_W'(1);
            if (32'(ext) > MAX_DIM)
                return CMP_W'(MAX_DIM);
            return ext;
        end
    endfunction

    logic [CMP_W-1:0] s_len;
    logic [CMP_W-1:0] t_len;
    logic             crop;
    logic [CMP_W-1:0] offset;
    logic [CMP_W-1:0] win_start;
    logic [CMP_W-1:0] win_end;
    logic [CMP_W-1:0] dst_start;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] coord_full;

    always_comb
    begin
        s_len      = clamp_dim(src_size);
        t_len      = clamp_dim(dst_size);
        crop       = s_len > t_len;
        offset     = center ? ((crop ? (s_len - t_len) : (t_len - s_len)) >> 1) : '0;
        win_start  = crop ? offset : '0;
        win_end    = win_start + (crop ? t_len : s_len);
        dst_start  = crop ? '0 : offset;
        cnt_ext    = CMP_W'(count);
        coord_full = cnt_ext - win_start + dst_start;

        map.hit   = (cnt_ext >= win_start) && (cnt_ext < win_end);
        map.last  = cnt_ext == (win_end - CMP_W'(1));
        map.wrap  = (cnt_ext + CMP_W'(1)) >= s_len;
        map.coord = coord_full[ccpe_pkg::COORD_W-1:0];
    end

endmodule

### sv/ccpe_checker.sv
// ---------------------------------------------------------------------------
// ccpe_checker: port-level checks for center_crop_palette_expand_top
// Watches the channel ports over time and reports violations.
// ---------------------------------------------------------------------------
module ccpe_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    input  logic                src_ready,
    input  logic                dst_valid,
    input  logic                dst_ready,
    input  ccpe_pkg::out_word_t dst_word
);

    // A stalled destination word holds until it is taken.
    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> dst_valid && $stable(dst_word))
        else $error("destination word changed while stalled");

    // The source side only backs up when a destination word is stalled.
    a_src_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !src_ready |-> dst_valid && !dst_ready)
        else $error("source stalled without a stalled destination word");

    // An error word sits at the origin and closes the frame.
    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_word.format_error |->
            dst_word.frame_last && dst_word.out_x == '0 && dst_word.out_y == '0)
        else $error("error word not at origin or not frame last");

    // Index and color fields are never both in use.
    a_color_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && (dst_word.out_red != '0 || dst_word.out_green != '0 ||
                      dst_word.out_blue != '0) |-> dst_word.out_index == '0)
        else $error("index and color both set");

    // Nothing is offered at the clock edge where reset is seen released.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !dst_valid)
        else $error("destination word present right after reset");

endmodule

bind center_crop_palette_expand_top ccpe_checker u_checker (.*);
